### sv/f2bls_pkg.sv
// shared types and conversion helpers for the fp32 to fp16/bf16 limb splitter
package f2bls_pkg;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        is_last;
  } f2bls_in_t;

  typedef struct packed {
    logic [15:0] high_limb;
    logic [15:0] low_limb;
    logic        last_out;
  } f2bls_out_t;

  localparam logic [1:0] FMT_FP16 = 2'd0;
  localparam logic [1:0] FMT_BF16 = 2'd1;
  localparam logic [1:0] FMT_TWO  = 2'd2;

  localparam logic [15:0] BF16_QNAN = 16'h7FC0;

  // bf16 round to nearest even of raw fp32 bits, nan quieted
  function automatic logic [15:0] to_bf16(input logic [31:0] b);
    logic [32:0] s;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
      return b[31:16] | 16'h0040;
    end
    s = {1'b0, b} + 33'h7FFF + {32'd0, b[16]};
    return s[31:16];
  endfunction

  // fp16 round to nearest even of raw fp32 bits
  function automatic logic [15:0] to_fp16(input logic [31:0] b);
    logic [15:0] sgn;
    logic [7:0]  ex;
    logic [22:0] mt;
    logic [23:0] m;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] half;
    logic [15:0] qn;
    logic [12:0] rn;
    sgn = {b[31], 15'd0};
    ex  = b[30:23];
    mt  = b[22:0];
    if (ex == 8'hFF) begin
      if (mt != 23'd0) return sgn | 16'h7E00 | {6'd0, mt[22:13]};
      return sgn | 16'h7C00;
    end
    if (ex >= 8'd143) return sgn | 16'h7C00;
    if (ex <= 8'd112) begin
      if (ex < 8'd102) return sgn;
      m    = {1'b1, mt};
      sh   = 5'(8'd126 - ex);
      q    = m >> sh;
      rem  = m & ((24'd1 << sh) - 24'd1);
      half = 24'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && q[0])) q = q + 24'd1;
      return sgn | q[15:0];
    end
    qn = {1'b0, 5'(ex - 8'd112), mt[22:13]};
    rn = mt[12:0];
    if (rn > 13'h1000 || (rn == 13'h1000 && qn[0])) qn = qn + 16'd1;
    return sgn | qn;
  endfunction

endpackage

### sv/float_to_bf16_limb_split.sv
// top level of the fp32 to fp16/bf16 limb splitter
// Streams one fp32 value per request on the input channel (valid/ready) and
// returns one result per request on the output channel: high_limb is fp16
// (format 0) or the nearest-even bf16 value, low_limb is the bf16 residual
// in format 2 and 3, else zero; last_out copies is_last.
// The format register is written over its own valid/ready channel, always
// ready, and must only change while the pipeline is empty.
// Output valid rises once a request has passed four register stages (round,
// residual subtract, normalize, final round/select), the first of which loads
// at the input accept edge itself.
// Throughput is one request per cycle. When the receiver stalls, every stage
// holds; an empty stage still fills, so ready drops only with the pipe full.
// Reset clears all stage valid bits and sets format to one bf16 limb.
module float_to_bf16_limb_split (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  f2bls_pkg::f2bls_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output f2bls_pkg::f2bls_out_t  out_data_o
);
  import f2bls_pkg::*;

  typedef struct packed {
    logic [31:0] val;
    logic [15:0] hi;
    logic        last;
    logic [1:0]  fmt;
  } s1_t;

  typedef struct packed {
    logic [31:0] val;
    logic [15:0] hi;
    logic        last;
    logic [1:0]  fmt;
    logic        sgn;
    logic [8:0]  ex;
    logic [24:0] mag;
  } s2_t;

  typedef struct packed {
    logic [31:0] val;
    logic [15:0] hi;
    logic        last;
    logic [1:0]  fmt;
    logic [31:0] rb;
  } s3_t;

  logic [1:0] fmt_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  f2bls_out_t o_d, o_q;
  logic r_sgn;
  logic [8:0] r_ex;
  logic [24:0] r_mag;
  logic [31:0] r_bits;
  logic [15:0] lo;

  assign cfg_ready_o = 1'b1;

  assign en4 = ~v4_q | out_ready_i;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BF16;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (cfg_valid_i) fmt_q <= cfg_data_i;
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: leading limb
  always_comb begin
    s1_d.val  = in_data_i.value_bits;
    s1_d.last = in_data_i.is_last;
    s1_d.fmt  = fmt_q;
    s1_d.hi   = (fmt_q == FMT_FP16) ? to_fp16(in_data_i.value_bits)
                                    : to_bf16(in_data_i.value_bits);
  end

  // stage 2: aligned subtract
  f2bls_resid u_resid (
    .value_i (s1_q.val),
    .hi_i    (s1_q.hi),
    .sign_o  (r_sgn),
    .exp_o   (r_ex),
    .mag_o   (r_mag)
  );

  always_comb begin
    s2_d.val  = s1_q.val;
    s2_d.hi   = s1_q.hi;
    s2_d.last = s1_q.last;
    s2_d.fmt  = s1_q.fmt;
    s2_d.sgn  = r_sgn;
    s2_d.ex   = r_ex;
    s2_d.mag  = r_mag;
  end

  // stage 3: normalize
  f2bls_norm u_norm (
    .sign_i (s2_q.sgn),
    .exp_i  (s2_q.ex),
    .mag_i  (s2_q.mag),
    .bits_o (r_bits)
  );

  always_comb begin
    s3_d.val  = s2_q.val;
    s3_d.hi   = s2_q.hi;
    s3_d.last = s2_q.last;
    s3_d.fmt  = s2_q.fmt;
    s3_d.rb   = r_bits;
  end

  // stage 4: special cases and residual rounding
  always_comb begin
    if (s3_q.val[30:23] == 8'hFF) begin
      lo = (s3_q.val[22:0] != 23'd0) ? s3_q.hi : BF16_QNAN;
    end else if (s3_q.hi[14:0] == 15'h7F80) begin
      lo = s3_q.hi ^ 16'h8000;
    end else begin
      lo = to_bf16(s3_q.rb);
    end
    o_d.high_limb = s3_q.hi;
    o_d.low_limb  = (s3_q.fmt[1]) ? lo : 16'd0;
    o_d.last_out  = s3_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) o_q  <= o_d;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = o_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && v4_q && !out_ready_i)
    else $error("input stalled with a free stage");
  a_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !s3_q.fmt[1] && en4 |=> out_data_o.low_limb == 16'd0)
    else $error("low limb set outside two-limb format");
endmodule

### sv/f2bls_resid.sv
// residual stage: exact value minus leading bf16 limb, as aligned fp32 fields
module f2bls_resid (
  input  logic [31:0] value_i,
  input  logic [15:0] hi_i,
  output logic        sign_o,
  output logic [8:0]  exp_o,
  output logic [24:0] mag_o
);
  import f2bls_pkg::*;

  // both operands share scale: magnitude difference is exact in 25 bits
  logic [23:0] mv, mh;
  logic [8:0]  ev, eh;
  logic [4:0]  d;
  logic [24:0] a, c;

  always_comb begin
    mv = {(value_i[30:23] != 8'd0), value_i[22:0]};
    ev = {1'b0, (value_i[30:23] == 8'd0) ? 8'd1 : value_i[30:23]};
    mh = {(hi_i[14:7] != 8'd0), hi_i[6:0], 16'd0};
    eh = {1'b0, (hi_i[14:7] == 8'd0) ? 8'd1 : hi_i[14:7]};
    // hi exponent is ev or ev+1; align to the larger
    if (eh > ev) begin
      d = 5'd1;
      a = {1'b0, mv} >> d;
      c = {1'b0, mh};
      exp_o = eh;
    end else begin
      d = 5'd0;
      a = {1'b0, mv};
      c = {1'b0, mh};
      exp_o = ev;
    end
    // low bit lost by the shift is kept by scaling up one
    a = {a[23:0], 1'b0} | {24'd0, (d != 5'd0) & mv[0]};
    c = {c[23:0], 1'b0};
    if (a >= c) begin
      mag_o  = a - c;
      sign_o = value_i[31];
    end else begin
      mag_o  = c - a;
      sign_o = ~value_i[31];
    end
  end
endmodule

### sv/f2bls_norm.sv
// normalize the residual magnitude into fp32 bits
module f2bls_norm (
  input  logic        sign_i,
  input  logic [8:0]  exp_i,
  input  logic [24:0] mag_i,
  output logic [31:0] bits_o
);
  import f2bls_pkg::*;

  logic [4:0]  lz;
  logic [24:0] sm;
  logic [9:0]  e;

  always_comb begin
    lz = 5'd0;
    sm = 25'd0;
    for (int i = 0; i < 25; i++) begin
      if (mag_i[i]) lz = 5'(24 - i);
    end
    // mag has one guard bit: a leading one at bit 24 means exponent exp_i
    e = {1'b0, exp_i} - {5'd0, lz};
    if (mag_i == 25'd0) begin
      bits_o = 32'd0;
    end else if ($signed(e) <= 0 || e[9]) begin
      // subnormal: shift as far as exponent 1 allows
      sm = mag_i << 5'(exp_i);
      bits_o = {sign_i, 8'd0, sm[24:2]};
    end else begin
      sm = mag_i << lz;
      bits_o = {sign_i, e[7:0], sm[23:1]};
    end
  end
endmodule
